[rtl/core/cpe_pkg.sv]
// Shared constants and codes for the camera pan easing unit.
`default_nettype none
package cpe_pkg;

    localparam int IN_W      = 32;
    localparam int OUT_W     = 72;
    localparam int STAT_W    = 2;
    localparam int ADDR_W    = 5;
    localparam int PDATA_W   = 32;
    localparam int DIV_W     = 32;
    localparam int DEN_W     = 16;
    localparam int DIV_CNT_W = 5;

    localparam logic [STAT_W-1:0] STAT_UPDATED  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_DISABLED = 2'd1;
    localparam logic [STAT_W-1:0] STAT_INACTIVE = 2'd2;

    localparam logic [2:0] REG_ENABLE   = 3'd0;
    localparam logic [2:0] REG_MODE     = 3'd1;
    localparam logic [2:0] REG_SMOOTH   = 3'd2;
    localparam logic [2:0] REG_START_X  = 3'd3;
    localparam logic [2:0] REG_START_Y  = 3'd4;
    localparam logic [2:0] REG_TARGET_X = 3'd5;
    localparam logic [2:0] REG_TARGET_Y = 3'd6;
    localparam logic [2:0] REG_DURATION = 3'd7;

    localparam logic [2:0] MODE_OFF   = 3'd0;
    localparam logic [2:0] MODE_START = 3'd1;
    localparam logic [2:0] MODE_RUN   = 3'd2;
    localparam logic [2:0] MODE_ONCE  = 3'd3;
    localparam logic [2:0] MODE_HOLD  = 3'd4;

    localparam logic [33:0] PI_Q32      = 34'h3243F6A89;
    localparam logic [11:0] ANG_HALF    = 12'd2048;
    localparam logic [11:0] ANG_QUARTER = 12'd1024;
    localparam logic [11:0] ANG_3Q      = 12'd3072;
    localparam logic [12:0] ANG_FULL    = 13'd4096;
    localparam logic [10:0] ANG_EIGHTH  = 11'd512;
    localparam logic [13:0] COS_ONE     = 14'd4096;
    localparam logic [34:0] COS_ROUND   = 35'h0_0008_0000;
    localparam logic [3:0]  SER_LAST    = 4'd11;

    localparam logic [15:0] SCREEN_CX = 16'd160;
    localparam logic [15:0] SCREEN_CY = 16'd112;

endpackage
`default_nettype wire

[rtl/core/cpe_divider.sv]
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module cpe_divider (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [cpe_pkg::DIV_W-1:0] dividend,
    input  logic [cpe_pkg::DEN_W-1:0] divisor,
    output logic                      done,
    output logic [cpe_pkg::DIV_W-1:0] quotient
);
    import cpe_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [DEN_W:0]       trial;
    logic                 fits;
    logic [DEN_W-1:0]     rem_next;

    always_comb begin
        trial    = {rem_reg, quo_reg[DIV_W-1]};
        fits     = trial >= {1'b0, den_reg};
        rem_next = fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            den_reg <= divisor;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

[rtl/core/camera_pan_easing_unit.sv]
// Camera pan easing unit: per-tick camera interpolation and centered viewport offsets.
// One item is one frame tick with the viewport size; one result comes back per item.
// A disabled or inactive tick goes straight to the finish step. Linear and cosine-eased
// ticks are paced by the shared restoring divider: two divides per linear tick, and one
// angle divide plus eleven series divides per eased tick; a single shared multiplier does
// all products.
`default_nettype none
module camera_pan_easing_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // view_width [15:0], view_height [31:16]
    input  logic [cpe_pkg::IN_W-1:0]    s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // cam_x [15:0], cam_y [31:16], offset_x [47:32], offset_y [63:48],
    // mode_now [66:64], finished [67], zero [71:68]
    output logic [cpe_pkg::OUT_W-1:0]   m_tdata,
    // status [1:0]
    output logic [cpe_pkg::STAT_W-1:0]  m_tuser,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cpe_pkg::ADDR_W-1:0]  paddr,
    input  logic [cpe_pkg::PDATA_W-1:0] pwdata,
    output logic [cpe_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import cpe_pkg::*;

    typedef enum logic [18:0] {
        S_IDLE     = 19'h00001,
        S_EVAL     = 19'h00002,
        S_LIN_MUL  = 19'h00004,
        S_LIN_DIV  = 19'h00008,
        S_LIN_SET  = 19'h00010,
        S_ANG_DIV  = 19'h00020,
        S_ANG      = 19'h00040,
        S_PI_MUL   = 19'h00080,
        S_SQ_MUL   = 19'h00100,
        S_SQ_SET   = 19'h00200,
        S_SER_ADD  = 19'h00400,
        S_SER_MUL  = 19'h00800,
        S_SER_DIV  = 19'h01000,
        S_SER_SET  = 19'h02000,
        S_COS      = 19'h04000,
        S_W_MUL    = 19'h08000,
        S_W_SET    = 19'h10000,
        S_DIV_WAIT = 19'h20000,
        S_FINISH   = 19'h40000
    } state_t;

    state_t state_reg, state_next, ret_reg;

    logic        enable_reg, smooth_reg;
    logic [2:0]  init_mode_reg;
    logic [15:0] start_x_reg, start_y_reg, target_x_reg, target_y_reg;
    logic [14:0] duration_reg;

    logic [2:0]  phase_reg;
    logic        done_flag_reg;
    logic [15:0] elapsed_reg;
    logic [15:0] cam_x_reg, cam_y_reg, offset_x_reg, offset_y_reg;

    logic [15:0]        view_w_reg, view_h_reg;
    logic [STAT_W-1:0]  status_reg;
    logic               axis_reg;
    logic [65:0]        prod_reg;
    logic [9:0]         mr_reg;
    logic               odd_reg, cneg_reg;
    logic [31:0]        x2_reg;
    logic [32:0]        term_reg;
    logic signed [34:0] sum_reg;
    logic [4:0]         n_reg;
    logic [3:0]         i_reg;
    logic [13:0]        w_reg;

    logic               m_tvalid_reg;
    logic [OUT_W-1:0]   m_tdata_reg;
    logic [STAT_W-1:0]  m_tuser_reg;

    logic              cfg_we;
    logic [2:0]        cfg_idx;
    logic [14:0]       dur_eff;
    logic [15:0]       delta_x, delta_y, cur_delta, cur_mag, cur_start, t_mag;
    logic              cur_neg, t_neg;
    logic [33:0]       mul_a;
    logic [31:0]       mul_b;
    logic              div_start, div_done;
    logic [DIV_W-1:0]  div_dividend, div_quot;
    logic [DEN_W-1:0]  div_divisor;
    logic [9:0]        n_p1, n_p2, ser_den;
    logic [31:0]       x_val;
    logic [15:0]       lin_mag, lin_m, w_mag, w_m, cam_new;
    logic [11:0]       q12, ang_k;
    logic [10:0]       qm;
    logic              qneg, qodd;
    logic [9:0]        qmr;
    logic signed [34:0] sum_next;
    logic [33:0]       s_pos;
    logic [34:0]       c_sum;
    logic [12:0]       c_mag;
    logic [13:0]       w_next;
    logic              out_free, fin_go, ended;
    logic [2:0]        ph1, fin_phase;
    logic              fin_done;
    logic [15:0]       tn, hw_sum, hh_sum, half_w, half_h, off_x_new, off_y_new;
    logic [15:0]       fin_offx, fin_offy;

    assign cfg_we  = psel & penable & pwrite;
    assign cfg_idx = paddr[ADDR_W-1:2];
    assign pready  = 1'b1;

    always_comb begin
        unique case (cfg_idx)
            REG_ENABLE:   prdata = PDATA_W'(enable_reg);
            REG_MODE:     prdata = PDATA_W'(init_mode_reg);
            REG_SMOOTH:   prdata = PDATA_W'(smooth_reg);
            REG_START_X:  prdata = PDATA_W'(start_x_reg);
            REG_START_Y:  prdata = PDATA_W'(start_y_reg);
            REG_TARGET_X: prdata = PDATA_W'(target_x_reg);
            REG_TARGET_Y: prdata = PDATA_W'(target_y_reg);
            REG_DURATION: prdata = PDATA_W'(duration_reg);
            default:      prdata = '0;
        endcase
    end

    always_comb begin
        dur_eff   = (duration_reg == '0) ? 15'd1 : duration_reg;
        delta_x   = target_x_reg - start_x_reg;
        delta_y   = target_y_reg - start_y_reg;
        cur_delta = axis_reg ? delta_y : delta_x;
        cur_start = axis_reg ? start_y_reg : start_x_reg;
        cur_neg   = cur_delta[15];
        cur_mag   = cur_neg ? 16'(-cur_delta) : cur_delta;
        t_neg     = elapsed_reg[15];
        t_mag     = t_neg ? 16'(-elapsed_reg) : elapsed_reg;
        x_val     = prod_reg[42:11];
        n_p1      = 10'(n_reg) + 10'd1;
        n_p2      = 10'(n_reg) + 10'd2;
        ser_den   = 10'(n_p1 * n_p2);
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_LIN_MUL: begin
                mul_a = 34'(cur_mag);
                mul_b = 32'(t_mag);
            end
            S_PI_MUL: begin
                mul_a = PI_Q32;
                mul_b = 32'(mr_reg);
            end
            S_SQ_MUL: begin
                mul_a = 34'(x_val);
                mul_b = x_val;
            end
            S_SER_MUL: begin
                mul_a = 34'(term_reg);
                mul_b = x2_reg;
            end
            S_W_MUL: begin
                mul_a = 34'(cur_mag);
                mul_b = 32'(w_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = 16'd1;
        case (state_reg)
            S_LIN_DIV: begin
                div_start    = 1'b1;
                div_dividend = prod_reg[DIV_W-1:0];
                div_divisor  = {1'b0, dur_eff};
            end
            S_ANG_DIV: begin
                div_start    = 1'b1;
                div_dividend = {5'b0, t_mag, 11'b0};
                div_divisor  = {1'b0, dur_eff};
            end
            S_SER_DIV: begin
                div_start    = 1'b1;
                div_dividend = prod_reg[63:32];
                div_divisor  = {6'b0, ser_den};
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    cpe_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb begin
        lin_mag = div_quot[15:0];
        lin_m   = (cur_neg ^ t_neg) ? 16'(-lin_mag) : lin_mag;
        w_mag   = prod_reg[28:13];
        w_m     = cur_neg ? 16'(-w_mag) : w_mag;
        cam_new = cur_start + ((state_reg == S_W_SET) ? w_m : lin_m);
    end

    always_comb begin
        q12   = t_neg ? 12'(-div_quot[11:0]) : div_quot[11:0];
        ang_k = q12 + ANG_HALF;
        qneg  = 1'b0;
        if (ang_k <= ANG_QUARTER) begin
            qm = ang_k[10:0];
        end else if (ang_k <= ANG_HALF) begin
            qm   = 11'(ANG_HALF - ang_k);
            qneg = 1'b1;
        end else if (ang_k <= ANG_3Q) begin
            qm   = 11'(ang_k - ANG_HALF);
            qneg = 1'b1;
        end else begin
            qm = 11'(ANG_FULL - {1'b0, ang_k});
        end
        qodd = qm > ANG_EIGHTH;
        qmr  = qodd ? 10'(ANG_QUARTER[10:0] - qm) : qm[9:0];
    end

    always_comb begin
        sum_next = i_reg[0] ? sum_reg - $signed({2'b0, term_reg})
                            : sum_reg + $signed({2'b0, term_reg});
        s_pos    = sum_reg[34] ? 34'd0 : sum_reg[33:0];
        c_sum    = {1'b0, s_pos} + COS_ROUND;
        c_mag    = c_sum[32:20];
        w_next   = cneg_reg ? COS_ONE - 14'(c_mag) : COS_ONE + 14'(c_mag);
    end

    always_comb begin
        out_free  = !m_tvalid_reg || m_tready;
        fin_go    = (state_reg == S_FINISH) && out_free;
        ph1       = (phase_reg == MODE_START) ? MODE_RUN : phase_reg;
        tn        = elapsed_reg + 16'd1;
        ended     = $signed(tn) > $signed({1'b0, dur_eff});
        hw_sum    = view_w_reg + 16'(view_w_reg[15]);
        hh_sum    = view_h_reg + 16'(view_h_reg[15]);
        half_w    = {hw_sum[15], hw_sum[15:1]};
        half_h    = {hh_sum[15], hh_sum[15:1]};
        off_x_new = SCREEN_CX - (cam_x_reg - half_w);
        off_y_new = SCREEN_CY - (cam_y_reg - half_h);
        if (status_reg == STAT_UPDATED) begin
            fin_phase = ended ? ((ph1 == MODE_RUN) ? MODE_HOLD : MODE_OFF) : ph1;
            fin_done  = done_flag_reg | ended;
            fin_offx  = off_x_new;
            fin_offy  = off_y_new;
        end else begin
            fin_phase = phase_reg;
            fin_done  = done_flag_reg;
            fin_offx  = offset_x_reg;
            fin_offy  = offset_y_reg;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     if (s_tvalid) state_next = S_EVAL;
            S_EVAL: begin
                if (!enable_reg || phase_reg < MODE_START || phase_reg > MODE_ONCE) begin
                    state_next = S_FINISH;
                end else begin
                    state_next = smooth_reg ? S_ANG_DIV : S_LIN_MUL;
                end
            end
            S_LIN_MUL:  state_next = S_LIN_DIV;
            S_LIN_DIV:  state_next = S_DIV_WAIT;
            S_LIN_SET:  state_next = axis_reg ? S_FINISH : S_LIN_MUL;
            S_ANG_DIV:  state_next = S_DIV_WAIT;
            S_ANG:      state_next = S_PI_MUL;
            S_PI_MUL:   state_next = S_SQ_MUL;
            S_SQ_MUL:   state_next = S_SQ_SET;
            S_SQ_SET:   state_next = S_SER_ADD;
            S_SER_ADD:  state_next = (i_reg == SER_LAST) ? S_COS : S_SER_MUL;
            S_SER_MUL:  state_next = S_SER_DIV;
            S_SER_DIV:  state_next = S_DIV_WAIT;
            S_SER_SET:  state_next = S_SER_ADD;
            S_COS:      state_next = S_W_MUL;
            S_W_MUL:    state_next = S_W_SET;
            S_W_SET:    state_next = axis_reg ? S_FINISH : S_W_MUL;
            S_DIV_WAIT: if (div_done) state_next = ret_reg;
            S_FINISH:   if (out_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                S_LIN_DIV: ret_reg <= S_LIN_SET;
                S_ANG_DIV: ret_reg <= S_ANG;
                S_SER_DIV: ret_reg <= S_SER_SET;
                default:   ret_reg <= ret_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg    <= 1'b0;
            init_mode_reg <= MODE_OFF;
            smooth_reg    <= 1'b0;
            start_x_reg   <= '0;
            start_y_reg   <= '0;
            target_x_reg  <= '0;
            target_y_reg  <= '0;
            duration_reg  <= 15'd1;
            phase_reg     <= MODE_OFF;
            done_flag_reg <= 1'b0;
            elapsed_reg   <= '0;
            cam_x_reg     <= '0;
            cam_y_reg     <= '0;
            offset_x_reg  <= '0;
            offset_y_reg  <= '0;
        end else begin
            if (cfg_we) begin
                elapsed_reg <= '0;
                unique case (cfg_idx)
                    REG_ENABLE: enable_reg <= pwdata[0];
                    REG_MODE: begin
                        init_mode_reg <= pwdata[2:0];
                        phase_reg     <= pwdata[2:0];
                    end
                    REG_SMOOTH:   smooth_reg   <= pwdata[0];
                    REG_START_X:  start_x_reg  <= pwdata[15:0];
                    REG_START_Y:  start_y_reg  <= pwdata[15:0];
                    REG_TARGET_X: target_x_reg <= pwdata[15:0];
                    REG_TARGET_Y: target_y_reg <= pwdata[15:0];
                    REG_DURATION: duration_reg <= pwdata[14:0];
                    default:      enable_reg   <= enable_reg;
                endcase
            end
            if ((state_reg == S_LIN_SET) || (state_reg == S_W_SET)) begin
                if (axis_reg) begin
                    cam_y_reg <= cam_new;
                end else begin
                    cam_x_reg <= cam_new;
                end
            end
            if (fin_go && (status_reg == STAT_UPDATED)) begin
                offset_x_reg  <= off_x_new;
                offset_y_reg  <= off_y_new;
                phase_reg     <= fin_phase;
                done_flag_reg <= fin_done;
                elapsed_reg   <= tn;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    view_w_reg <= s_tdata[15:0];
                    view_h_reg <= s_tdata[31:16];
                end
            end
            S_EVAL: begin
                axis_reg <= 1'b0;
                if (!enable_reg) begin
                    status_reg <= STAT_DISABLED;
                end else if (phase_reg < MODE_START || phase_reg > MODE_ONCE) begin
                    status_reg <= STAT_INACTIVE;
                end else begin
                    status_reg <= STAT_UPDATED;
                end
            end
            S_LIN_MUL, S_PI_MUL, S_SER_MUL, S_W_MUL: begin
                prod_reg <= mul_a * mul_b;
            end
            S_LIN_SET, S_W_SET: begin
                axis_reg <= 1'b1;
            end
            S_ANG: begin
                mr_reg   <= qmr;
                odd_reg  <= qodd;
                cneg_reg <= qneg;
            end
            S_SQ_MUL: begin
                prod_reg <= mul_a * mul_b;
                term_reg <= odd_reg ? {1'b0, x_val} : 33'h1_0000_0000;
                n_reg    <= {4'b0, odd_reg};
                i_reg    <= '0;
                sum_reg  <= '0;
            end
            S_SQ_SET: begin
                x2_reg <= prod_reg[63:32];
            end
            S_SER_ADD: begin
                sum_reg <= sum_next;
            end
            S_SER_SET: begin
                term_reg <= {1'b0, div_quot};
                n_reg    <= n_reg + 5'd2;
                i_reg    <= i_reg + 4'd1;
            end
            S_COS: begin
                w_reg    <= w_next;
                axis_reg <= 1'b0;
            end
            default: begin
                axis_reg <= axis_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (fin_go) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_go) begin
            m_tdata_reg <= {4'b0, fin_done, fin_phase, fin_offy, fin_offx, cam_y_reg, cam_x_reg};
            m_tuser_reg <= status_reg;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_div_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == S_DIV_WAIT))
        else $error("divider finished outside its wait step");

    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == S_FINISH))
        else $error("result raised outside the finish step");

    a_done_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && $past(done_flag_reg)) |-> done_flag_reg)
        else $error("done flag cleared without reset");

endmodule
`default_nettype wire

[tb/tb_camera_pan_easing_unit.sv]
// Self-checking testbench for the camera pan easing unit: directed table, then random pans.
module tb_camera_pan_easing_unit;
    import cpe_pkg::*;

    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;
    localparam longint unsigned PI_FRAC  = 64'h3_243F_6A89;
    localparam int RANDOM_TICKS = 530;
    localparam int CALM_TICKS   = 60;

    typedef struct packed {
        logic [1:0]  stat;
        logic [15:0] cam_x;
        logic [15:0] cam_y;
        logic [15:0] off_x;
        logic [15:0] off_y;
        logic [2:0]  mode;
        logic        fin;
    } pan_result_t;

    typedef struct packed {
        logic        is_write;
        logic [2:0]  reg_idx;
        logic [31:0] wdata;
        logic [15:0] width;
        logic [15:0] height;
        logic        fixed;
        pan_result_t want;
    } stim_row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_W-1:0]    m_tdata;
    logic [STAT_W-1:0]   m_tuser;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    camera_pan_easing_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // predicted register file and pan state
    logic        cfg_enable = 1'b0;
    logic [2:0]  cfg_mode = MODE_OFF;
    logic        cfg_smooth = 1'b0;
    logic [15:0] cfg_start_x = '0, cfg_start_y = '0, cfg_target_x = '0, cfg_target_y = '0;
    logic [14:0] cfg_duration = 15'd1;
    logic [2:0]  pan_phase = MODE_OFF;
    logic        pan_done = 1'b0;
    logic [15:0] pan_elapsed = '0;
    logic [15:0] held_cam_x = '0, held_cam_y = '0, held_off_x = '0, held_off_y = '0;

    pan_result_t expected_frames[$];
    stim_row_t   stim_rows[$];
    int          mismatch_count = 0;
    int          tick_count = 0;
    int          eased_count = 0;
    int          linear_count = 0;
    int          write_count = 0;
    bit          idle_on = 1'b1;
    int          ready_stall = 0;

    function automatic longint trig_series(longint unsigned x, bit odd_start);
        longint unsigned x2, term, n;
        longint          sum;
        x2 = (x * x) >> 32;
        term = odd_start ? x : 64'h1_0000_0000;
        n = odd_start ? 1 : 0;
        sum = 0;
        for (int i = 0; i < 12; i++) begin
            if (i % 2 == 1) sum -= longint'(term);
            else sum += longint'(term);
            term = (term * x2) >> 32;
            term = term / ((n + 1) * (n + 2));
            n += 2;
        end
        return sum;
    endfunction

    function automatic int quarter_cosine(longint unsigned m);
        longint s;
        if (m <= 512) s = trig_series((PI_FRAC * m) / 2048, 1'b0);
        else s = trig_series((PI_FRAC * (1024 - m)) / 2048, 1'b1);
        if (s < 0) s = 0;
        return int'((s * 4096 + 64'sh8000_0000) >>> 32);
    endfunction

    function automatic int cosine_q12(int a);
        logic [11:0] k;
        k = a[11:0];
        if (k <= 12'd1024) return quarter_cosine(k);
        if (k <= 12'd2048) return -quarter_cosine(2048 - k);
        if (k <= 12'd3072) return -quarter_cosine(k - 2048);
        return quarter_cosine(4096 - k);
    endfunction

    function automatic void apply_register(logic [2:0] idx, logic [31:0] wdata);
        logic [15:0] v;
        v = wdata[15:0];
        case (idx)
            REG_ENABLE:   cfg_enable = v[0];
            REG_MODE: begin
                cfg_mode = v[2:0];
                pan_phase = v[2:0];
            end
            REG_SMOOTH:   cfg_smooth = v[0];
            REG_START_X:  cfg_start_x = v;
            REG_START_Y:  cfg_start_y = v;
            REG_TARGET_X: cfg_target_x = v;
            REG_TARGET_Y: cfg_target_y = v;
            REG_DURATION: cfg_duration = v[14:0];
            default: ;
        endcase
        pan_elapsed = '0;
    endfunction

    function automatic pan_result_t advance_camera(logic [15:0] width, logic [15:0] height);
        pan_result_t       r;
        logic signed [15:0] dx16, dy16, t16, cx16, cy16, w16, h16;
        int                dx, dy, t, d, mx, my, wgt, cxi, cyi, wi, hi;
        r.stat = STAT_UPDATED;
        if (!cfg_enable) begin
            r.stat = STAT_DISABLED;
        end else if (pan_phase < MODE_START || pan_phase > MODE_ONCE) begin
            r.stat = STAT_INACTIVE;
        end else begin
            dx16 = cfg_target_x - cfg_start_x;
            dy16 = cfg_target_y - cfg_start_y;
            t16 = pan_elapsed;
            dx = dx16;
            dy = dy16;
            t = t16;
            d = cfg_duration;
            if (d == 0) d = 1;
            if (!cfg_smooth) begin
                mx = dx * t / d;
                my = dy * t / d;
            end else begin
                wgt = cosine_q12(t * 2048 / d + 2048) + 4096;
                mx = dx * wgt / 8192;
                my = dy * wgt / 8192;
            end
            held_cam_x = cfg_start_x + mx[15:0];
            held_cam_y = cfg_start_y + my[15:0];
            cx16 = held_cam_x;
            cy16 = held_cam_y;
            w16 = width;
            h16 = height;
            cxi = cx16;
            cyi = cy16;
            wi = w16;
            hi = h16;
            held_off_x = 16'(160 - (cxi - wi / 2));
            held_off_y = 16'(112 - (cyi - hi / 2));
            if (pan_phase == MODE_START) pan_phase = MODE_RUN;
            pan_elapsed = pan_elapsed + 16'd1;
            t16 = pan_elapsed;
            if (int'(t16) > d) begin
                pan_phase = (pan_phase == MODE_RUN) ? MODE_HOLD : MODE_OFF;
                pan_done = 1'b1;
            end
        end
        r.cam_x = held_cam_x;
        r.cam_y = held_cam_y;
        r.off_x = held_off_x;
        r.off_y = held_off_y;
        r.mode = pan_phase;
        r.fin = pan_done;
        return r;
    endfunction

    function automatic pan_result_t frame(logic [1:0] stat, logic [15:0] cx, logic [15:0] cy,
                                          logic [15:0] ox, logic [15:0] oy, logic [2:0] mode,
                                          logic fin);
        pan_result_t r;
        r.stat = stat;
        r.cam_x = cx;
        r.cam_y = cy;
        r.off_x = ox;
        r.off_y = oy;
        r.mode = mode;
        r.fin = fin;
        return r;
    endfunction

    function automatic void add_write(logic [2:0] idx, logic [31:0] wdata);
        stim_row_t row;
        row = '0;
        row.is_write = 1'b1;
        row.reg_idx = idx;
        row.wdata = wdata;
        stim_rows.push_back(row);
    endfunction

    function automatic void add_tick(logic [15:0] width, logic [15:0] height, logic fixed,
                                     pan_result_t want);
        stim_row_t row;
        row = '0;
        row.width = width;
        row.height = height;
        row.fixed = fixed;
        row.want = want;
        stim_rows.push_back(row);
    endfunction

    function automatic logic [15:0] pick_dim();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(0, 640));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(0, 4))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom);
            default: return 16'($urandom_range(0, 2000)) - 16'd1000;
        endcase
    endfunction

    // entered and left at a falling edge
    task automatic apb_write(logic [2:0] idx, logic [31:0] wdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        apply_register(idx, wdata);
        write_count++;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge aclk);
    endtask

    // write a register with random junk above the field now and then
    task automatic write_field(logic [2:0] idx, logic [31:0] value, logic [31:0] mask);
        logic [31:0] junk;
        junk = $urandom;
        if ($urandom_range(0, 3) == 0) apb_write(idx, (value & mask) | (junk & ~mask));
        else apb_write(idx, value & mask);
    endtask

    task automatic drive_tick(logic [15:0] width, logic [15:0] height, logic fixed,
                              pan_result_t want);
        pan_result_t got;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {height, width};
        do @(posedge aclk); while (!s_tready);
        got = advance_camera(width, height);
        if (got.stat == STAT_UPDATED) begin
            if (cfg_smooth) eased_count++;
            else linear_count++;
        end
        expected_frames.push_back(fixed ? want : got);
        tick_count++;
        @(negedge aclk);
    endtask

    // hold the sender until every expected item has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_frames.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic report(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(negedge aclk) begin
        if (ready_stall > 0) begin
            ready_stall <= ready_stall - 1;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            ready_stall <= $urandom_range(0, 5);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        pan_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_frames.size() == 0) begin
                $display("%0t: unexpected item, expected none, got %h/%h",
                         $time, m_tuser, m_tdata);
                mismatch_count++;
            end else begin
                want = expected_frames.pop_front();
                report("status", 16'(want.stat), 16'(m_tuser));
                report("cam_x", want.cam_x, m_tdata[15:0]);
                report("cam_y", want.cam_y, m_tdata[31:16]);
                report("offset_x", want.off_x, m_tdata[47:32]);
                report("offset_y", want.off_y, m_tdata[63:48]);
                report("mode_now", 16'(want.mode), 16'(m_tdata[66:64]));
                report("finished", 16'(want.fin), 16'(m_tdata[67]));
                report("padding", 16'd0, 16'(m_tdata[71:68]));
            end
        end
    end

    initial begin
        #(12 * 4_000_000);
        $display("camera_pan_easing_unit test failed");
        $finish;
    end

    initial begin
        pan_result_t none;
        bit          in_flight;
        int          random_ticks, span, dur_eff, pick;
        logic [14:0] dur;
        none = '0;
        in_flight = 1'b0;
        random_ticks = 0;

        add_tick(16'd320, 16'd224, 1'b1,
                 frame(STAT_DISABLED, 16'd0, 16'd0, 16'd0, 16'd0, MODE_OFF, 1'b0));
        add_write(REG_ENABLE, 32'd1);
        add_tick(16'd320, 16'd224, 1'b1,
                 frame(STAT_INACTIVE, 16'd0, 16'd0, 16'd0, 16'd0, MODE_OFF, 1'b0));
        add_write(REG_MODE, 32'(MODE_SPARE_LO));
        add_tick(16'd320, 16'd224, 1'b1,
                 frame(STAT_INACTIVE, 16'd0, 16'd0, 16'd0, 16'd0, MODE_SPARE_LO, 1'b0));
        add_write(REG_MODE, 32'(MODE_SPARE_HI));
        add_tick(16'h8000, 16'h7FFF, 1'b0, none);
        add_write(REG_TARGET_X, 32'd100);
        add_write(REG_DURATION, 32'd1);
        add_write(REG_MODE, 32'(MODE_START));
        add_tick(16'd320, 16'd224, 1'b1,
                 frame(STAT_UPDATED, 16'd0, 16'd0, 16'd320, 16'd224, MODE_RUN, 1'b0));
        add_tick(16'd320, 16'd224, 1'b1,
                 frame(STAT_UPDATED, 16'd100, 16'd0, 16'd220, 16'd224, MODE_HOLD, 1'b1));
        add_tick(16'd320, 16'd224, 1'b1,
                 frame(STAT_INACTIVE, 16'd100, 16'd0, 16'd220, 16'd224, MODE_HOLD, 1'b1));
        add_write(REG_START_X, 32'h8000);
        add_write(REG_TARGET_X, 32'h7FFF);
        add_write(REG_START_Y, 32'h7FFF);
        add_write(REG_TARGET_Y, 32'h8000);
        add_write(REG_DURATION, 32'd3);
        add_write(REG_MODE, 32'(MODE_ONCE));
        add_tick(16'h7FFF, 16'h8000, 1'b0, none);
        add_tick(16'hFFFF, 16'h0001, 1'b0, none);
        add_tick(16'h0000, 16'h0000, 1'b0, none);
        add_tick(16'h8000, 16'h8000, 1'b0, none);
        add_tick(16'h7FFF, 16'h7FFF, 1'b0, none);
        add_write(REG_SMOOTH, 32'd1);
        add_write(REG_START_X, 32'd0);
        add_write(REG_DURATION, 32'h8000);
        add_write(REG_MODE, 32'(MODE_START));
        add_tick(16'd320, 16'd224, 1'b0, none);
        add_tick(16'hFFFE, 16'h0003, 1'b0, none);
        add_tick(16'd64, 16'd48, 1'b0, none);
        add_write(REG_DURATION, 32'hFFFF);
        add_write(REG_MODE, 32'(MODE_RUN));
        add_tick(16'd320, 16'd224, 1'b0, none);
        add_tick(16'd100, 16'd200, 1'b0, none);
        add_write(REG_START_X, 32'hFC18);
        add_write(REG_TARGET_X, 32'd1000);
        add_write(REG_START_Y, 32'd500);
        add_write(REG_TARGET_Y, 32'hFE0C);
        add_write(REG_DURATION, 32'd6);
        add_write(REG_MODE, 32'(MODE_ONCE));
        for (int i = 0; i < 8; i++) add_tick(16'd320 + 16'(i), 16'd224 - 16'(i), 1'b0, none);
        add_write(REG_ENABLE, 32'd0);
        add_tick(16'd0, 16'd0, 1'b0, none);

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < stim_rows.size(); i++) begin
            if (stim_rows[i].is_write) begin
                if (in_flight) settle();
                in_flight = 1'b0;
                apb_write(stim_rows[i].reg_idx, stim_rows[i].wdata);
            end else begin
                drive_tick(stim_rows[i].width, stim_rows[i].height, stim_rows[i].fixed,
                           stim_rows[i].want);
                in_flight = 1'b1;
            end
        end

        while (random_ticks < RANDOM_TICKS) begin
            settle();
            idle_on = (random_ticks < RANDOM_TICKS - CALM_TICKS);
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                write_field(REG_ENABLE, $urandom_range(0, 1), 32'h1);
                write_field(REG_MODE, $urandom_range(0, 7), 32'h7);
                span = $urandom_range(2, 6);
            end else begin
                write_field(REG_ENABLE, 32'd1, 32'h1);
                if ($urandom_range(0, 3) != 0) write_field(REG_SMOOTH, $urandom_range(0, 1), 32'h1);
                if ($urandom_range(0, 3) != 0) write_field(REG_START_X, pick_coord(), 32'hFFFF);
                if ($urandom_range(0, 3) != 0) write_field(REG_START_Y, pick_coord(), 32'hFFFF);
                if ($urandom_range(0, 3) != 0) write_field(REG_TARGET_X, pick_coord(), 32'hFFFF);
                if ($urandom_range(0, 3) != 0) write_field(REG_TARGET_Y, pick_coord(), 32'hFFFF);
                if ($urandom_range(0, 3) != 0) begin
                    case ($urandom_range(0, 19))
                        0: dur = 15'd0;
                        1: dur = 15'h7FFF;
                        2: dur = 15'($urandom_range(13, 32767));
                        default: dur = 15'($urandom_range(1, 12));
                    endcase
                    write_field(REG_DURATION, 32'(dur), 32'h7FFF);
                end
                case ($urandom_range(0, 9))
                    0, 1: write_field(REG_MODE, 32'(MODE_RUN), 32'h7);
                    2, 3, 4: write_field(REG_MODE, 32'(MODE_ONCE), 32'h7);
                    default: write_field(REG_MODE, 32'(MODE_START), 32'h7);
                endcase
                dur_eff = (cfg_duration == 0) ? 1 : int'(cfg_duration);
                if (dur_eff <= 12) span = dur_eff + 1 + $urandom_range(0, 3);
                else span = $urandom_range(3, 16);
            end
            for (int j = 0; j < span; j++) begin
                drive_tick(pick_dim(), pick_dim(), 1'b0, none);
                random_ticks++;
            end
        end

        settle();
        repeat (50) @(negedge aclk);
        $display("covered %0d ticks: %0d linear and %0d eased updates, the rest held",
                 tick_count, linear_count, eased_count);
        $display("%0d register writes across enable, mode, easing, endpoints and duration",
                 write_count);
        if (mismatch_count == 0) begin
            $display("camera_pan_easing_unit test passed");
        end else begin
            $display("camera_pan_easing_unit test failed");
        end
        $finish;
    end

endmodule
